// ===== hdl/debuf_pkg.sv =====
package debuf_pkg;

  // Operation codes carried on func.
  localparam logic [2:0] OP_PUSH_END   = 3'd0;
  localparam logic [2:0] OP_PUSH_START = 3'd1;
  localparam logic [2:0] OP_POP_END    = 3'd2;
  localparam logic [2:0] OP_POP_START  = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;
  localparam logic [2:0] OP_WRITE      = 3'd5;

  // Status codes returned with every result.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned STATUS_W = 2;

  // Result bookkeeping handed from the controller to the top level.
  typedef struct packed {
    logic                valid;
    logic                take_data;
    logic [STATUS_W-1:0] status;
  } resp_t;

endpackage

// ===== hdl/debuf_mem.sv =====
module debuf_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [debuf_pkg::DATA_W-1:0] wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [debuf_pkg::DATA_W-1:0] rdata
);
  import debuf_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/debuf_ctrl.sv =====
module debuf_ctrl #(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned PW       = 8,
  parameter int unsigned CW       = 9
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [debuf_pkg::FUNC_W-1:0]   func,
  input  logic [debuf_pkg::DATA_W-1:0]   value,
  input  logic [debuf_pkg::INDEX_W-1:0]  index,
  output logic                           mem_we,
  output logic [PW-1:0]                  mem_waddr,
  output logic [debuf_pkg::DATA_W-1:0]   mem_wdata,
  output logic                           mem_re,
  output logic [PW-1:0]                  mem_raddr,
  output logic [CW-1:0]                  held,
  output debuf_pkg::resp_t               resp
);
  import debuf_pkg::*;

  localparam int unsigned XW = (CW > INDEX_W) ? CW : INDEX_W;

  logic [PW-1:0] head, head_next;
  logic [CW-1:0] held_next;
  logic          busy_q;
  resp_t         resp_next;

  logic          accept;
  logic          full, empty, in_range;
  logic [CW-1:0] offset;
  logic [CW:0]   sum;
  logic [PW-1:0] phys;
  logic [PW-1:0] head_inc, head_dec;
  logic [XW-1:0] index_x;

  assign accept  = start & ~busy_q;
  assign busy    = busy_q;
  assign full    = (held == CW'(CAPACITY));
  assign empty   = (held == '0);
  assign index_x = XW'(index);
  assign in_range = (index_x < XW'(held));

  assign head_inc = (head == PW'(CAPACITY - 1)) ? '0 : head + PW'(1);
  assign head_dec = (head == '0) ? PW'(CAPACITY - 1) : head - PW'(1);

  // Logical position to physical entry of the ring.
  always_comb begin
    case (func)
      OP_PUSH_END: offset = held;
      OP_POP_END:  offset = held - CW'(1);
      default:     offset = index_x[CW-1:0];
    endcase
    sum = (CW + 1)'(head) + (CW + 1)'(offset);
    if (sum >= (CW + 1)'(CAPACITY)) begin
      sum = sum - (CW + 1)'(CAPACITY);
    end
    phys = sum[PW-1:0];
  end

  always_comb begin
    head_next       = head;
    held_next       = held;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_waddr       = phys;
    mem_raddr       = phys;
    mem_wdata       = value;
    resp_next.valid     = accept;
    resp_next.take_data = 1'b0;
    resp_next.status    = ST_OK;
    case (func)
      OP_PUSH_END, OP_PUSH_START: begin
        if (full) begin
          resp_next.status = ST_FULL;
        end else begin
          mem_we    = accept;
          held_next = held + CW'(1);
          if (func == OP_PUSH_START) begin
            mem_waddr = head_dec;
            head_next = head_dec;
          end
        end
      end
      OP_POP_END, OP_POP_START: begin
        if (empty) begin
          resp_next.status = ST_EMPTY;
        end else begin
          mem_re              = accept;
          resp_next.take_data = 1'b1;
          held_next           = held - CW'(1);
          if (func == OP_POP_START) begin
            mem_raddr = head;
            head_next = head_inc;
          end
        end
      end
      OP_READ: begin
        if (!in_range) begin
          resp_next.status = ST_RANGE;
        end else begin
          mem_re              = accept;
          resp_next.take_data = 1'b1;
        end
      end
      OP_WRITE: begin
        if (!in_range) begin
          resp_next.status = ST_RANGE;
        end else begin
          mem_we = accept;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      held       <= '0;
      busy_q     <= 1'b1;
      resp.valid <= 1'b0;
    end else begin
      busy_q     <= 1'b0;
      resp.valid <= resp_next.valid;
      if (accept) begin
        head           <= head_next;
        held           <= held_next;
        resp.take_data <= resp_next.take_data;
        resp.status    <= resp_next.status;
      end
    end
  end

endmodule

// ===== hdl/double_ended_array_buffer.sv =====
// Channel   | Signals                          | Transfer
// ----------+----------------------------------+-----------------------------------
// command   | start, busy, func, value, index  | edge with start high and busy low
// result    | done, read_data, count, status   | edge ending the cycle done is high
//
// One command is taken per clock cycle while busy is low; its result appears
// on the result ports in the cycle right after the command transfer, for one
// cycle only. The rate is set by the single-port-per-direction element
// memory: each command makes at most one memory access, so commands never
// collide. busy is set while rst is high, clears at the first edge with rst
// low and stays low. The receiver cannot stall, so no result is ever held back.
module double_ended_array_buffer #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [debuf_pkg::FUNC_W-1:0]         func,
  input  logic signed [debuf_pkg::DATA_W-1:0] value,
  input  logic [debuf_pkg::INDEX_W-1:0]        index,
  output logic                                 done,
  output logic signed [debuf_pkg::DATA_W-1:0]  read_data,
  output logic [debuf_pkg::COUNT_W-1:0]        count,
  output logic [debuf_pkg::STATUS_W-1:0]       status
);
  import debuf_pkg::*;

  // The elements live in a ring: a head pointer marks the first element,
  // so pushing or popping at the start moves the pointer instead of
  // shifting every element. Logical position i sits at (head + i) mod
  // CAPACITY.
  localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned WW = (CW > COUNT_W) ? CW : COUNT_W;

  logic              mem_we;
  logic [PW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [PW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  logic [CW-1:0]     held;
  logic [WW-1:0]     held_w;
  resp_t             resp;

  debuf_ctrl #(
    .CAPACITY (CAPACITY),
    .PW       (PW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .value     (value),
    .index     (index),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .held      (held),
    .resp      (resp)
  );

  debuf_mem #(
    .DEPTH (CAPACITY),
    .AW    (PW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The count register already holds the value after the last command,
  // which is exactly what the result reports in the following cycle.
  assign held_w    = WW'(held);
  assign done      = resp.valid;
  assign read_data = resp.take_data ? mem_rdata : '0;
  assign count     = held_w[COUNT_W-1:0];
  assign status    = resp.status;

endmodule

// ===== hdl/debuf_chk.sv =====
module debuf_chk (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 done,
  input logic signed [debuf_pkg::DATA_W-1:0]  read_data,
  input logic [debuf_pkg::COUNT_W-1:0]        count,
  input logic [debuf_pkg::STATUS_W-1:0]       status
);
  import debuf_pkg::*;

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("result missing after command transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without command transfer");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (count == '0 && read_data == '0))
    else $error("empty status with elements or data");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_RANGE) |-> (read_data == '0))
    else $error("out-of-range result carries data");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (done && $past(done) && !$past(rst)) |->
      (count == $past(count) || count == $past(count) + COUNT_W'(1) ||
       count == $past(count) - COUNT_W'(1)))
    else $error("count moved by more than one");

endmodule

bind double_ended_array_buffer debuf_chk u_debuf_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .read_data (read_data),
  .count     (count),
  .status    (status)
);

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import debuf_pkg::*;

  // The buffer is built with its default capacity of 256 words, so a full
  // store holds exactly as many elements as an 8-bit index can address.
  localparam int unsigned DEPTH = 256;

  // Codes six and seven on func are unused and must act as no operation.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

  // The longest quiet stretch in a correct run is a sender gap or the reset
  // window, both far shorter than IDLE_LIMIT, so an idle stretch that reaches
  // this limit without any transfer means the block has hung.
  localparam int unsigned IDLE_LIMIT = 2000;

  // Reports beyond this many mismatches are only counted.
  localparam int unsigned REPORT_LIMIT = 10;

  // One result as it appears on the result ports.
  typedef struct {
    logic signed [DATA_W-1:0] read_data;
    logic [COUNT_W-1:0]       count;
    logic [STATUS_W-1:0]      status;
  } deque_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [FUNC_W-1:0]        func = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic [INDEX_W-1:0]       index = '0;
  logic                     done;
  logic signed [DATA_W-1:0] read_data;
  logic [COUNT_W-1:0]       count;
  logic [STATUS_W-1:0]      status;

  // Shadow copy of the buffer contents and fill level. It is updated in the
  // same order in which the block accepts commands, so it always mirrors
  // the state the block should have after the last accepted transfer.
  logic signed [DATA_W-1:0] shadow_cells [DEPTH];
  int unsigned              shadow_count = 0;

  // Results the block still owes, oldest first.
  deque_result_t pending_results [$];

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  // Percentage of command transfers that are followed by a pause of the
  // sender. Zero gives a stretch of back-to-back commands.
  int unsigned gap_pct = 0;

  double_ended_array_buffer #(
    .CAPACITY (DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .value     (value),
    .index     (index),
    .done      (done),
    .read_data (read_data),
    .count     (count),
    .status    (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one command to the shadow buffer and returns the result the
  // block must produce for it. Pushes shift or append, pops shift or trim,
  // and every rejected command leaves the shadow state untouched.
  function automatic deque_result_t predict_deque_op(logic [FUNC_W-1:0] f,
                                                      logic signed [DATA_W-1:0] v,
                                                      logic [INDEX_W-1:0] idx);
    deque_result_t r;
    int unsigned   i;
    r.read_data = '0;
    r.status    = ST_OK;
    case (f)
      OP_PUSH_END: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_cells[shadow_count] = v;
          shadow_count++;
        end
      end
      OP_PUSH_START: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_count; i > 0; i--) shadow_cells[i] = shadow_cells[i - 1];
          shadow_cells[0] = v;
          shadow_count++;
        end
      end
      OP_POP_END: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.read_data = shadow_cells[shadow_count - 1];
          shadow_count--;
        end
      end
      OP_POP_START: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.read_data = shadow_cells[0];
          // Only held elements move down; nothing past the last one is touched.
          for (i = 0; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i + 1];
          shadow_count--;
        end
      end
      OP_READ: begin
        if (idx >= shadow_count) r.status = ST_RANGE;
        else r.read_data = shadow_cells[idx];
      end
      OP_WRITE: begin
        if (idx >= shadow_count) r.status = ST_RANGE;
        else shadow_cells[idx] = v;
      end
      default: begin
      end
    endcase
    r.count = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  // Checker. Every edge is looked at once: a result strobed in the cycle that
  // this edge closes is matched against the oldest owed result, and a command
  // transfer at this edge adds its predicted result to the back of the queue.
  // All signals are read right after the edge, before any nonblocking update
  // of this time step lands, so both sides see the values sampled at the edge.
  always @(posedge clk) begin
    deque_result_t want;
    if (done === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: read_data %0d count %0d status %0d",
                   read_data, count, status);
      end else begin
        want = pending_results.pop_front();
        if (read_data !== want.read_data || count !== want.count ||
            status !== want.status) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("mismatch: read_data exp %0d got %0d, count exp %0d got %0d, %s",
                     want.read_data, read_data, want.count, count,
                     $sformatf("status exp %0d got %0d", want.status, status));
        end
      end
    end
    if (start === 1'b1 && busy === 1'b0)
      pending_results.push_back(predict_deque_op(func, value, index));
  end

  // Watchdog: any transfer on either channel counts as progress.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Data words lean toward the extremes now and then so that the sign bit,
  // all-ones and all-zeros patterns show up often next to plain random words.
  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Presents one command and holds it until the block takes it. Afterwards
  // the sender may pause for a burst of idle cycles. When there is no pause,
  // start stays high and the next command follows in the very next cycle.
  task automatic send_op(input logic [FUNC_W-1:0] f,
                         input logic signed [DATA_W-1:0] v,
                         input logic [INDEX_W-1:0] idx);
    start <= 1'b1;
    func  <= f;
    value <= v;
    index <= idx;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Stops the sender and waits until every owed result has arrived. After
  // this the shadow state is exact, which the capacity test relies on.
  task automatic wait_all_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Rejections on an empty store, the unused codes, extreme data words at
  // both ends, reads and writes in and out of range, then a full drain from
  // both ends down to empty again.
  task automatic test_directed();
    gap_pct = 30;
    send_op(OP_POP_END, '0, '0);
    send_op(OP_POP_START, '0, '0);
    send_op(OP_READ, '0, '0);
    send_op(OP_WRITE, 32'sh1234_5678, '0);
    send_op(FUNC_UNUSED_LO, -32'sd1, 8'hff);
    send_op(FUNC_UNUSED_HI, 32'sh7fff_ffff, 8'h00);
    send_op(OP_PUSH_END, 32'sh7fff_ffff, '0);
    send_op(OP_PUSH_START, 32'sh8000_0000, '0);
    send_op(OP_PUSH_END, -32'sd1, 8'hff);
    send_op(OP_PUSH_START, '0, '0);
    send_op(OP_READ, '0, 8'd0);
    send_op(OP_READ, '0, 8'd3);
    send_op(OP_READ, '0, 8'd4);
    send_op(OP_READ, '0, 8'd255);
    send_op(OP_WRITE, 32'sh5555_5555, 8'd1);
    send_op(OP_WRITE, 32'shaaaa_aaaa, 8'd2);
    send_op(OP_WRITE, 32'sh0f0f_0f0f, 8'd4);
    send_op(OP_READ, '0, 8'd1);
    send_op(OP_READ, '0, 8'd2);
    send_op(OP_POP_START, '0, '0);
    send_op(OP_POP_END, '0, '0);
    send_op(OP_POP_START, '0, '0);
    send_op(OP_POP_START, '0, '0);
    send_op(OP_POP_END, '0, '0);
  endtask

  // Fills the store to capacity from both ends, checks that further pushes
  // are refused, touches the last slot that an index can reach, and drains
  // it again from both ends until a pop is refused. The sender first waits
  // for every owed result so that the fill level is known exactly.
  task automatic test_full_store();
    int unsigned fill;
    wait_all_results();
    fill = DEPTH - shadow_count;
    gap_pct = 5;
    repeat (fill)
      send_op($urandom_range(0, 1) ? OP_PUSH_END : OP_PUSH_START, pick_word(),
              INDEX_W'($urandom_range(0, 255)));
    send_op(OP_PUSH_END, pick_word(), '0);
    send_op(OP_PUSH_START, pick_word(), '0);
    send_op(OP_READ, '0, 8'd255);
    send_op(OP_WRITE, pick_word(), 8'd255);
    send_op(OP_READ, '0, 8'd255);
    send_op(OP_WRITE, pick_word(), 8'd0);
    send_op(OP_READ, '0, 8'd0);
    send_op(FUNC_UNUSED_HI, pick_word(), 8'd128);
    repeat (DEPTH / 2)
      send_op(OP_POP_START, pick_word(), INDEX_W'($urandom_range(0, 255)));
    repeat (DEPTH / 2)
      send_op(OP_POP_END, pick_word(), INDEX_W'($urandom_range(0, 255)));
    send_op(OP_POP_END, '0, '0);
  endtask

  // Random commands with the given weights for pushes and pops. Reads and
  // writes mostly aim inside the held range, the rest hit random indexes;
  // a small share uses the unused codes.
  task automatic random_ops(input int unsigned n, input int unsigned push_w,
                            input int unsigned pop_w);
    int unsigned       pick;
    logic [FUNC_W-1:0] f;
    logic [INDEX_W-1:0] idx;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < push_w)
        f = $urandom_range(0, 1) ? OP_PUSH_END : OP_PUSH_START;
      else if (pick < push_w + pop_w)
        f = $urandom_range(0, 1) ? OP_POP_END : OP_POP_START;
      else if (pick < 95)
        f = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
      else
        f = $urandom_range(0, 1) ? FUNC_UNUSED_LO : FUNC_UNUSED_HI;
      if (shadow_count > 0 && $urandom_range(0, 9) < 8)
        idx = INDEX_W'($urandom_range(0, shadow_count - 1));
      else
        idx = INDEX_W'($urandom_range(0, 255));
      send_op(f, pick_word(), idx);
    end
  endtask

  // Growth and shrink phases alternate so that the fill level wanders over
  // a wide band; each phase picks its own sender idling density.
  task automatic test_random_traffic();
    int unsigned phase;
    for (phase = 0; phase < 4; phase++) begin
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 50;
      endcase
      if (phase % 2 == 0) random_ops(25, 55, 15);
      else random_ops(25, 15, 50);
    end
  endtask

  // Closing stretch with commands on every cycle and no idling at all.
  task automatic test_back_to_back();
    gap_pct = 0;
    random_ops(80, 35, 30);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_store();
    test_random_traffic();
    test_back_to_back();

    // Let the last result come back, then keep watching the result ports so
    // that any stray result would be flagged by the checker.
    wait_all_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/debuf_pkg.sv
hdl/debuf_mem.sv
hdl/debuf_ctrl.sv
hdl/double_ended_array_buffer.sv
hdl/debuf_chk.sv
tb/sv/tb_top.sv
